>>> sv/lkv_pkg.sv
// Shared constants, types and helper functions of the LRU key/value cache.
package lkv_pkg;

	// Number of slots built into the store.
	localparam int MAX_ENTRIES = 16;
	// Width of a slot index and of a recency age.
	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	// Width of the entry count, which must hold MAX_ENTRIES itself.
	localparam int COUNT_W = $clog2(MAX_ENTRIES + 1);
	// Width of the capacity register and of the key and value fields.
	localparam int CAP_W = 5;
	localparam int DATA_W = 32;

	// Request kinds.
	localparam logic REQ_GET = 1'b0;
	localparam logic REQ_PUT = 1'b1;

	// Result values that do not come from a slot.
	localparam logic [DATA_W-1:0] MISS_VALUE = {DATA_W{1'b1}};
	localparam logic [DATA_W-1:0] PUT_VALUE = '0;

	// Capacity in force after reset.
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(MAX_ENTRIES);

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [IDX_W-1:0] age_t;
	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [DATA_W-1:0] data_t;

	// One request as held in the input register.
	typedef struct packed {
		logic  is_put;
		data_t key;
		data_t value;
	} lkv_req_t;

	// Outcome of the lookup: which slot is touched and how the ages move.
	typedef struct packed {
		logic   hit;
		logic   update;
		logic   insert;
		idx_t   target;
		count_t thresh;
	} lkv_sel_t;

	// Occupancy of the store, visible to the top level.
	typedef struct packed {
		logic [MAX_ENTRIES-1:0] valid;
		count_t                 count;
	} lkv_status_t;

	// A capacity of zero counts as one; larger values saturate at the slot count.
	function automatic count_t eff_capacity(input logic [CAP_W-1:0] cap);
		count_t c;
		if (cap == '0) begin
			c = count_t'(1);
		end else if (int'(cap) > MAX_ENTRIES) begin
			c = count_t'(MAX_ENTRIES);
		end else begin
			c = count_t'(cap);
		end
		return c;
	endfunction

endpackage

>>> sv/lkv_lookup.sv
// Parallel key match and slot selection for the LRU key/value cache.
module lkv_lookup import lkv_pkg::*; (
	input  lkv_req_t               req,
	input  logic [MAX_ENTRIES-1:0] slot_valid,
	input  data_t                  slot_key [MAX_ENTRIES],
	input  age_t                   slot_age [MAX_ENTRIES],
	input  count_t                 entry_count,
	input  count_t                 capacity,
	output lkv_sel_t               sel
);

	logic                   hit;
	idx_t                   found;
	idx_t                   victim;
	idx_t                   free_slot;
	logic                   full;
	logic [MAX_ENTRIES-1:0] match;
	count_t                 oldest;

	assign full   = (entry_count >= capacity);
	assign oldest = entry_count - count_t'(1);

	// Compare the key against every valid slot at once.
	always_comb begin
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			match[i] = slot_valid[i] && (slot_key[i] == req.key);
		end
	end

	// Encode the matching slot, the least recent slot and the lowest free slot.
	always_comb begin
		hit       = 1'b0;
		found     = '0;
		victim    = '0;
		free_slot = '0;
		for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit   = 1'b1;
				found = idx_t'(i);
			end
			if (slot_valid[i] && (count_t'(slot_age[i]) == oldest)) begin
				victim = idx_t'(i);
			end
			if (!slot_valid[i]) begin
				free_slot = idx_t'(i);
			end
		end
	end

	// Choose the slot to touch. Slots younger than the threshold age by one.
	always_comb begin
		sel.hit    = hit;
		sel.update = hit || (req.is_put == REQ_PUT);
		sel.insert = (req.is_put == REQ_PUT) && !hit && !full;
		if (hit) begin
			sel.target = found;
			sel.thresh = count_t'(slot_age[found]);
		end else if (full) begin
			sel.target = victim;
			sel.thresh = oldest;
		end else begin
			sel.target = free_slot;
			sel.thresh = entry_count;
		end
	end

endmodule

>>> sv/lkv_slot_array.sv
// Slot storage, recency ages and the registered update of the LRU cache.
module lkv_slot_array import lkv_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  lkv_req_t         req,
	input  logic [CAP_W-1:0] capacity,
	output logic             hit,
	output data_t            read_value,
	output lkv_status_t      status
);

	logic [MAX_ENTRIES-1:0] valid_q;
	data_t                  key_q   [MAX_ENTRIES];
	data_t                  value_q [MAX_ENTRIES];
	age_t                   age_q   [MAX_ENTRIES];
	count_t                 count_q;
	lkv_sel_t               sel;

	lkv_lookup u_lookup (
		.req         (req),
		.slot_valid  (valid_q),
		.slot_key    (key_q),
		.slot_age    (age_q),
		.entry_count (count_q),
		.capacity    (eff_capacity(capacity)),
		.sel         (sel)
	);

	// Result of the request in the input register.
	always_comb begin
		hit = sel.hit;
		if (req.is_put == REQ_PUT) begin
			read_value = PUT_VALUE;
		end else if (sel.hit) begin
			read_value = value_q[sel.target];
		end else begin
			read_value = MISS_VALUE;
		end
	end

	// Valid bits, ages and the entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				age_q[i] <= '0;
			end
		end else if (step && sel.update) begin
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				if (idx_t'(i) == sel.target) begin
					age_q[i] <= '0;
				end else if (valid_q[i] && (count_t'(age_q[i]) < sel.thresh)) begin
					age_q[i] <= age_q[i] + age_t'(1);
				end
			end
			if (sel.insert) begin
				valid_q[sel.target] <= 1'b1;
				count_q             <= count_q + count_t'(1);
			end
		end
	end

	// Keys and values are written only by a put.
	always_ff @(posedge clk) begin
		if (step && (req.is_put == REQ_PUT)) begin
			value_q[sel.target] <= req.value;
			if (!sel.hit) begin
				key_q[sel.target] <= req.key;
			end
		end
	end

	assign status.valid = valid_q;
	assign status.count = count_q;

endmodule

>>> sv/lru_key_value_cache_core.sv
// Top level of the fully associative LRU key/value cache.
// The cache holds up to sixteen key/value pairs in fixed slots with a recency
// age per slot, and replaces the least recently used entry when a put misses
// a full store. A transaction is taken into the input register; when it moves
// on, all slots are compared at once, the ages and the entry are updated and
// the result is loaded into the output register. One transaction is accepted
// every cycle as long as results are taken. A get miss returns all ones with
// hit clear, and a put returns zero. The capacity register (reset 16, zero
// read as one, above sixteen read as sixteen) is to be written only while the
// cache is empty and idle.
module lru_key_value_cache_core import lkv_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CAP_W-1:0]   cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               req_type,
	input  logic signed [31:0] lookup_key,
	input  logic signed [31:0] write_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               hit,
	output logic signed [31:0] read_value
);

	logic [CAP_W-1:0] capacity_q;
	logic             valid_s1;
	lkv_req_t         req_s1;
	logic             advance;
	logic             res_hit;
	data_t            res_value;
	lkv_status_t      status;
	logic             out_valid_q;
	logic             hit_q;
	data_t            read_value_q;

	// Capacity register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_we) begin
			capacity_q <= cfg_wdata;
		end
	end

	// The input register moves on whenever the output register is empty or its result is taken.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1.is_put <= req_type;
			req_s1.key    <= data_t'(lookup_key);
			req_s1.value  <= data_t'(write_value);
		end
	end

	lkv_slot_array u_slots (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.req        (req_s1),
		.capacity   (capacity_q),
		.hit        (res_hit),
		.read_value (res_value),
		.status     (status)
	);

	// Output register holding the finished transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			hit_q        <= res_hit;
			read_value_q <= res_value;
		end
	end

	assign out_valid  = out_valid_q;
	assign hit        = hit_q;
	assign read_value = $signed(read_value_q);

	// The entry count never passes the number of slots.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(status.count) <= MAX_ENTRIES)
		else $error("entry count exceeds the slot count");

	// The entry count always equals the number of valid slots.
	a_count_match: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(status.valid) == int'(status.count))
		else $error("entry count disagrees with valid slots");

	// Input is refused only while both registers are full and the output stalls.
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q && !out_ready))
		else $error("input refused without a stall");

	// A transaction leaving the input register shows up at the output.
	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("result lost on its way to the output register");

endmodule

>>> tb/tb.sv
// Self-checking testbench for the LRU key/value cache core.
`timescale 1ns / 100ps

module tb;
	import lkv_pkg::*;

	// Kinds of row in the directed stimulus table.
	typedef enum logic [1:0] {
		ROW_GET,
		ROW_PUT,
		ROW_CFG
	} row_kind_t;

	// One reply of the cache as the checker sees it.
	typedef struct packed {
		logic  hit;
		data_t value;
	} cache_reply_t;

	// One row of the directed table; for a capacity row the value holds the setting.
	typedef struct packed {
		row_kind_t    kind;
		data_t        key;
		data_t        value;
		logic         typed;
		cache_reply_t reply;
	} stim_row_t;

	localparam int DIRECTED_ROWS = 25;
	localparam int SEGMENTS = 10;
	localparam int SEGMENT_ITEMS = 50;
	localparam int POOL_SIZE = 48;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 4;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_we;
	logic [CAP_W-1:0]   cfg_wdata;
	logic               in_valid;
	logic               in_ready;
	logic               req_type;
	logic signed [31:0] lookup_key;
	logic signed [31:0] write_value;
	logic               out_valid;
	logic               out_ready;
	logic               hit;
	logic signed [31:0] read_value;

	// Shadow copy of the cache contents and of the capacity register.
	logic             cache_valid [MAX_ENTRIES];
	data_t            cache_key [MAX_ENTRIES];
	data_t            cache_value [MAX_ENTRIES];
	age_t             cache_age [MAX_ENTRIES];
	int               cache_count;
	logic [CAP_W-1:0] cache_cap;

	cache_reply_t pending_replies [$];
	stim_row_t    directed_rows [DIRECTED_ROWS];
	data_t        key_pool [POOL_SIZE];
	int           error_count;
	int           quiet_cycles;
	int           send_idle_pct;
	int           recv_idle_pct;

	lru_key_value_cache_core u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.lookup_key  (lookup_key),
		.write_value (write_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.hit         (hit),
		.read_value  (read_value)
	);

	// Free-running clock with a 12 ns period.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Number of entries the cache may fill before it starts to evict.
	function automatic int cap_limit();
		int c;
		c = int'(cache_cap);
		if (c == 0) begin
			c = 1;
		end else if (c > MAX_ENTRIES) begin
			c = MAX_ENTRIES;
		end
		return c;
	endfunction

	// Make a slot the most recent; every valid slot younger than it ages by one.
	function automatic void promote_slot(input int s);
		age_t a;
		a = cache_age[s];
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (cache_valid[i] && i != s && cache_age[i] < a) begin
				cache_age[i] = cache_age[i] + 1'b1;
			end
		end
		cache_age[s] = '0;
	endfunction

	// Apply one request to the shadow cache and return the reply it should give.
	function automatic cache_reply_t lru_access(input logic is_put, input data_t key,
			input data_t val);
		cache_reply_t reply;
		int           found;
		int           slot;
		age_t         oldest;
		found = -1;
		slot = -1;
		oldest = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (found < 0 && cache_valid[i] && cache_key[i] == key) begin
				found = i;
			end
		end
		reply.hit = (found >= 0);
		if (is_put == REQ_GET) begin
			if (found >= 0) begin
				reply.value = cache_value[found];
				promote_slot(found);
			end else begin
				reply.value = MISS_VALUE;
			end
		end else begin
			reply.value = PUT_VALUE;
			if (found >= 0) begin
				promote_slot(found);
				cache_value[found] = val;
			end else if (cache_count >= cap_limit() && cache_count > 0) begin
				// Full store: the least recent entry carries the largest age.
				for (int i = 0; i < MAX_ENTRIES; i++) begin
					if (cache_valid[i] && (slot < 0 || cache_age[i] > oldest)) begin
						oldest = cache_age[i];
						slot = i;
					end
				end
				promote_slot(slot);
				cache_key[slot] = key;
				cache_value[slot] = val;
			end else begin
				// Room left: take the free slot with the lowest index.
				for (int i = 0; i < MAX_ENTRIES; i++) begin
					if (slot < 0 && !cache_valid[i]) begin
						slot = i;
					end
				end
				if (slot >= 0) begin
					for (int j = 0; j < MAX_ENTRIES; j++) begin
						if (cache_valid[j]) begin
							cache_age[j] = cache_age[j] + 1'b1;
						end
					end
					cache_valid[slot] = 1'b1;
					cache_key[slot] = key;
					cache_value[slot] = val;
					cache_age[slot] = '0;
					cache_count++;
				end
			end
		end
		return reply;
	endfunction

	task automatic report_mismatch(input string msg);
		if (error_count < 100) begin
			$display("ERROR at %0t ns: %s", $time, msg);
		end
		error_count++;
	endtask

	// Present one request, wait for the transaction and record its reply.
	task automatic send_request(input logic is_put, input data_t key, input data_t val,
			input logic typed, input cache_reply_t typed_reply);
		cache_reply_t reply;
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= is_put;
		lookup_key <= key;
		write_value <= val;
		do begin
			@(posedge clk);
		end while (!in_ready);
		reply = lru_access(is_put, key, val);
		pending_replies.push_back(typed ? typed_reply : reply);
	endtask

	// Stop sending and wait until every reply has come back.
	task automatic drain_cache();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_replies.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] cap);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= cap;
		@(negedge clk);
		cfg_we <= 1'b0;
		cache_cap = cap;
	endtask

	// Receiver: stall the reply channel at the rate of the current phase.
	always @(negedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// Compare every reply with the oldest one still awaited.
	always @(posedge clk) begin
		cache_reply_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_replies.size() == 0) begin
				report_mismatch($sformatf("reply with none awaited: hit %b value %h",
					hit, read_value));
			end else begin
				want = pending_replies.pop_front();
				if (hit !== want.hit) begin
					report_mismatch($sformatf("hit is %b, expected %b", hit, want.hit));
				end
				if (read_value !== want.value) begin
					report_mismatch($sformatf("read_value is %h, expected %h",
						read_value, want.value));
				end
			end
		end
	end

	// Watchdog on cycles in which neither channel completes a transaction.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		stim_row_t    row;
		logic         is_put;
		data_t        key;
		int           held;
		int           span;
		logic [CAP_W-1:0] seg_caps [SEGMENTS];

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		req_type = REQ_GET;
		lookup_key = '0;
		write_value = '0;
		out_ready = 1'b0;
		error_count = 0;
		quiet_cycles = 0;
		send_idle_pct = 23;
		recv_idle_pct = 81;
		cache_count = 0;
		cache_cap = CAP_RESET;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			cache_valid[i] = 1'b0;
			cache_key[i] = '0;
			cache_value[i] = '0;
			cache_age[i] = '0;
		end

		// Directed part: single-entry cache, saturated and lowered capacity.
		directed_rows = '{
			'{ROW_CFG, 32'h0, 32'h0, 1'b0, '{1'b0, 32'h0}},
			'{ROW_GET, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{1'b0, MISS_VALUE}},
			'{ROW_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, '{1'b0, PUT_VALUE}},
			'{ROW_GET, 32'h7FFF_FFFF, 32'h0, 1'b1, '{1'b1, 32'h8000_0000}},
			'{ROW_PUT, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, '{1'b0, PUT_VALUE}},
			'{ROW_GET, 32'h7FFF_FFFF, 32'h0, 1'b1, '{1'b0, MISS_VALUE}},
			'{ROW_GET, 32'h8000_0000, 32'h0, 1'b1, '{1'b1, 32'hFFFF_FFFF}},
			'{ROW_PUT, 32'h8000_0000, 32'h0000_0000, 1'b1, '{1'b1, PUT_VALUE}},
			'{ROW_GET, 32'h8000_0000, 32'h0, 1'b1, '{1'b1, 32'h0000_0000}},
			'{ROW_CFG, 32'h0, 32'd31, 1'b0, '{1'b0, 32'h0}},
			'{ROW_PUT, 32'h0000_0001, 32'h0000_0011, 1'b0, '{1'b0, 32'h0}},
			'{ROW_PUT, 32'h0000_0002, 32'h0000_0022, 1'b0, '{1'b0, 32'h0}},
			'{ROW_PUT, 32'h0000_0003, 32'h0000_0033, 1'b0, '{1'b0, 32'h0}},
			'{ROW_PUT, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0, '{1'b0, 32'h0}},
			'{ROW_GET, 32'h0000_0002, 32'h0, 1'b0, '{1'b0, 32'h0}},
			'{ROW_GET, 32'h0000_0001, 32'h0, 1'b0, '{1'b0, 32'h0}},
			'{ROW_CFG, 32'h0, 32'd2, 1'b0, '{1'b0, 32'h0}},
			'{ROW_PUT, 32'h0000_0005, 32'h0000_0055, 1'b0, '{1'b0, 32'h0}},
			'{ROW_GET, 32'h8000_0000, 32'h0, 1'b0, '{1'b0, 32'h0}},
			'{ROW_GET, 32'h0000_0003, 32'h0, 1'b0, '{1'b0, 32'h0}},
			'{ROW_PUT, 32'h0000_0002, 32'h5555_AAAA, 1'b0, '{1'b0, 32'h0}},
			'{ROW_GET, 32'h0000_0002, 32'h0, 1'b0, '{1'b0, 32'h0}},
			'{ROW_CFG, 32'h0, 32'd16, 1'b0, '{1'b0, 32'h0}},
			'{ROW_PUT, 32'h0000_0006, 32'h0000_0066, 1'b0, '{1'b0, 32'h0}},
			'{ROW_GET, 32'h0000_0006, 32'h0, 1'b0, '{1'b0, 32'h0}}
		};

		// Capacity of each random segment, extremes included.
		seg_caps = '{5'd3, 5'd0, 5'd7, 5'd1, 5'd12, 5'd16, 5'd31, 5'd4, 5'd9, 5'd16};

		// Key pool: the corner keys first, the rest random.
		key_pool[0] = 32'h0000_0000;
		key_pool[1] = 32'h7FFF_FFFF;
		key_pool[2] = 32'h8000_0000;
		key_pool[3] = 32'hFFFF_FFFF;
		for (int i = 4; i < POOL_SIZE; i++) begin
			key_pool[i] = $urandom();
		end

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < DIRECTED_ROWS; r++) begin
			row = directed_rows[r];
			if (row.kind == ROW_CFG) begin
				drain_cache();
				write_capacity(row.value[CAP_W-1:0]);
			end else begin
				send_request(row.kind == ROW_PUT ? REQ_PUT : REQ_GET, row.key, row.value,
					row.typed, row.reply);
			end
		end

		// Random part: keys mostly drawn from a window of the pool slightly larger
		// than the store, so hits, updates and evictions all occur.
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			drain_cache();
			if (seg == 4) begin
				send_idle_pct = 81;
				recv_idle_pct = 23;
			end else if (seg == 7) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_capacity(seg_caps[seg]);
			for (int n = 0; n < SEGMENT_ITEMS; n++) begin
				if (seg == 5 && n == SEGMENT_ITEMS / 2) begin
					drain_cache();
				end
				held = (cache_count > cap_limit()) ? cache_count : cap_limit();
				span = held + $urandom_range(1, 4);
				if ($urandom_range(0, 9) == 0) begin
					key = $urandom();
				end else begin
					key = key_pool[(seg * 5 + $urandom_range(0, span - 1)) % POOL_SIZE];
				end
				is_put = ($urandom_range(0, 1) == 1) ? REQ_PUT : REQ_GET;
				send_request(is_put, key, $urandom(), 1'b0, '{1'b0, 32'h0});
			end
		end

		drain_cache();
		if (error_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
